// ===== src/sdspi_pkg.sv =====
// Package for the SD card SPI-mode host engine.
// Holds phase codes, command opcodes, continuation codes and request codes.
`timescale 1ns / 1ps
`default_nettype none
package sdspi_pkg;
  localparam logic [3:0] PH_IDLE  = 4'd0;
  localparam logic [3:0] PH_DUMMY = 4'd1;
  localparam logic [3:0] PH_CMD   = 4'd2;
  localparam logic [3:0] PH_TOKEN = 4'd3;
  localparam logic [3:0] PH_FRAME = 4'd4;
  localparam logic [3:0] PH_WHDR  = 4'd5;
  localparam logic [3:0] PH_WDATA = 4'd6;
  localparam logic [3:0] PH_WZERO = 4'd7;
  localparam logic [3:0] PH_WRESP = 4'd8;
  localparam logic [3:0] PH_WBUSY = 4'd9;
  localparam logic [3:0] PH_TAIL  = 4'd10;

  localparam logic [7:0] OPC_IDLE      = 8'h40;
  localparam logic [7:0] OPC_OPCOND    = 8'h41;
  localparam logic [7:0] OPC_IFCOND    = 8'h48;
  localparam logic [7:0] OPC_BLKLEN    = 8'h50;
  localparam logic [7:0] OPC_RDBLK     = 8'h51;
  localparam logic [7:0] OPC_WRBLK     = 8'h58;
  localparam logic [7:0] OPC_APP       = 8'h77;
  localparam logic [7:0] OPC_OCR       = 8'h7A;
  localparam logic [7:0] OPC_APPOPCOND = 8'hE9;

  localparam logic [3:0] K_IDLE   = 4'd0;
  localparam logic [3:0] K_IFCOND = 4'd1;
  localparam logic [3:0] K_HCS    = 4'd2;
  localparam logic [3:0] K_OCR    = 4'd3;
  localparam logic [3:0] K_PROBE  = 4'd4;
  localparam logic [3:0] K_LOW    = 4'd5;
  localparam logic [3:0] K_BLKLEN = 4'd6;
  localparam logic [3:0] K_RDBLK  = 4'd7;
  localparam logic [3:0] K_WRBLK  = 4'd8;

  localparam logic [2:0] CMD_INIT   = 3'd0;
  localparam logic [2:0] CMD_READ   = 3'd1;
  localparam logic [2:0] CMD_WBEGIN = 3'd2;
  localparam logic [2:0] CMD_WDATA  = 3'd3;
  localparam logic [2:0] CMD_WFIN   = 3'd4;
  localparam logic [2:0] CMD_RX     = 3'd5;

  localparam logic [1:0] OP_INIT  = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;

  localparam logic [1:0] REG_RESP  = 2'd0;
  localparam logic [1:0] REG_RETRY = 2'd1;
  localparam logic [1:0] REG_TOKEN = 2'd2;
  localparam logic [1:0] REG_BUSY  = 2'd3;

  localparam logic [9:0] FRAME_LEN = 10'd514;
  localparam logic [9:0] SECTOR_LEN = 10'd512;
endpackage
`default_nettype wire

// ===== src/sd_card_spi_host_engine.sv =====
// SD card SPI-mode host engine: init, partial read and sector write sequencing.
// Depends on sdspi_pkg.
//
// channel | dir | fields (lowest bit first)
// in_     | in  | tdata: command, sector, offset, count, write_byte, rx_byte
// out_    | out | tdata: tx_valid, tx_byte, card_select, read_valid, read_byte,
//         |     |        done_res, status, card_type
// cfg_    | in  | index 0..3, data 16 bits
//
// Each transfer is handled by the combinational step logic and lands in an
// output register; a transfer may be accepted every cycle unless the output is stalled.
// The input is taken whenever the output register is empty or is being drained.
// Reset is synchronous and active low; it restores all limits to defaults.
`timescale 1ns / 1ps
`default_nettype none
module sd_card_spi_host_engine (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [71:0] in_tdata,   // command, sector, offset, count, write_byte, rx_byte
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // tx_valid, tx_byte, card_select, read_valid,
                                       // read_byte, done_res, status, card_type
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);
  import sdspi_pkg::*;

  logic [7:0]  resp_lim_r;
  logic [15:0] retry_lim_r, token_lim_r, busy_lim_r;
  logic [3:0]  phase_r, phase_nxt;
  logic [2:0]  kind_r, kind_nxt;
  logic [7:0]  cidx_r, cidx_nxt;
  logic [31:0] arg_r, arg_nxt;
  logic [9:0]  fpos_r, fpos_nxt;
  logic [15:0] wait_r, wait_nxt, retry_r, retry_nxt;
  logic [7:0]  rb_r [4];
  logic [7:0]  last_r, last_nxt;
  logic [9:0]  wrem_r, wrem_nxt, rrem_r, rrem_nxt, rstart_r, rstart_nxt;
  logic        cs_r, cs_nxt;
  logic [3:0]  stage_r, stage_nxt;
  logic [7:0]  rleft_r, rleft_nxt;
  logic [2:0]  ridx_r, ridx_nxt;
  logic [2:0]  extra_r, extra_nxt;
  logic        apppend_r, apppend_nxt;
  logic [7:0]  appcmd_r, appcmd_nxt;
  logic [31:0] apparg_r, apparg_nxt;
  logic [2:0]  appext_r, appext_nxt;
  logic [3:0]  after_r, after_nxt;
  logic [7:0]  poll_r, poll_nxt;
  logic [1:0]  op_r, op_nxt;
  logic        opst_r, opst_nxt;
  logic        rb_we;
  logic [1:0]  rb_wa;

  logic        o_txv, o_rdv, o_done;
  logic [7:0]  o_tx, o_rd;
  logic [1:0]  o_st;
  logic        out_valid_r;
  logic [31:0] out_data_r;

  logic [2:0]  i_cmd;
  logic [31:0] i_sector;
  logic [9:0]  i_offset, i_count;
  logic [7:0]  i_wbyte, i_rx;
  logic        take;
  logic [9:0]  fpos_inc;

  assign i_cmd    = in_tdata[2:0];
  assign i_sector = in_tdata[34:3];
  assign i_offset = in_tdata[44:35];
  assign i_count  = in_tdata[54:45];
  assign i_wbyte  = in_tdata[62:55];
  assign i_rx     = in_tdata[70:63];

  assign in_tready  = !out_valid_r || out_tready;
  assign take       = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign fpos_inc   = fpos_r + 10'd1;

  always_comb begin
    logic       cont;
    logic       cmpl;
    logic [7:0] rr;
    logic [7:0] sc; logic [31:0] sa; logic [2:0] se; logic [3:0] sk;
    logic       do_start;
    logic       do_issue;
    logic [7:0] ic; logic [31:0] ia; logic [2:0] ie;
    logic       do_tail;
    logic [7:0] rb3;
    phase_nxt = phase_r; kind_nxt = kind_r; cidx_nxt = cidx_r; arg_nxt = arg_r;
    fpos_nxt = fpos_r; wait_nxt = wait_r; retry_nxt = retry_r; last_nxt = last_r;
    wrem_nxt = wrem_r; rrem_nxt = rrem_r; rstart_nxt = rstart_r; cs_nxt = cs_r;
    stage_nxt = stage_r; rleft_nxt = rleft_r; ridx_nxt = ridx_r; extra_nxt = extra_r;
    apppend_nxt = apppend_r; appcmd_nxt = appcmd_r; apparg_nxt = apparg_r;
    appext_nxt = appext_r; after_nxt = after_r; poll_nxt = poll_r; op_nxt = op_r;
    opst_nxt = opst_r; rb_we = 1'b0; rb_wa = ridx_r[1:0];
    o_txv = 1'b0; o_tx = 8'h00; o_rdv = 1'b0; o_rd = 8'h00; o_done = 1'b0; o_st = 2'd0;
    cmpl = 1'b0; rr = last_r; cont = 1'b0;
    do_start = 1'b0; sc = 8'h00; sa = 32'h0; se = 3'd0; sk = K_IDLE;
    do_issue = 1'b0; ic = 8'h00; ia = 32'h0; ie = 3'd0; do_tail = 1'b0;

    if (phase_r == PH_IDLE) begin
      case (i_cmd)
        CMD_INIT: begin
          op_nxt = OP_INIT; kind_nxt = 3'd0; cs_nxt = 1'b0; wait_nxt = 16'd19;
          phase_nxt = PH_DUMMY; o_txv = 1'b1; o_tx = 8'hFF;
        end
        CMD_READ: begin
          op_nxt = OP_READ; rstart_nxt = i_offset; rrem_nxt = i_count;
          do_start = 1'b1; sc = OPC_RDBLK; sk = K_RDBLK;
          sa = (kind_r == 3'd4) ? i_sector : {i_sector[22:0], 9'd0};
        end
        CMD_WBEGIN: begin
          op_nxt = OP_WRITE; do_start = 1'b1; sc = OPC_WRBLK; sk = K_WRBLK;
          sa = (kind_r == 3'd4) ? i_sector : {i_sector[22:0], 9'd0};
        end
        CMD_WDATA: begin
          op_nxt = OP_WRITE;
          if (wrem_r != 10'd0) begin
            wrem_nxt = wrem_r - 10'd1; phase_nxt = PH_WDATA; o_txv = 1'b1; o_tx = i_wbyte;
          end else begin
            o_done = 1'b1;
          end
        end
        CMD_WFIN: begin
          op_nxt = OP_WRITE; wait_nxt = {6'd0, wrem_r} + 16'd1;
          phase_nxt = PH_WZERO; o_txv = 1'b1; o_tx = 8'h00;
        end
        default: ;
      endcase
    end else if (i_cmd == CMD_RX) begin
      case (phase_r)
        PH_DUMMY: begin
          if (wait_r != 16'd0) begin
            wait_nxt = wait_r - 16'd1; o_txv = 1'b1; o_tx = 8'hFF;
          end else begin
            do_start = 1'b1; sc = OPC_IDLE; sk = K_IDLE;
          end
        end
        PH_CMD: begin
          case (stage_r)
            4'd0: begin cs_nxt = 1'b1; stage_nxt = 4'd1; o_txv = 1'b1; o_tx = 8'hFF; end
            4'd1: begin stage_nxt = 4'd2; o_txv = 1'b1; o_tx = cidx_r; end
            4'd2: begin stage_nxt = 4'd3; o_txv = 1'b1; o_tx = arg_r[31:24]; end
            4'd3: begin stage_nxt = 4'd4; o_txv = 1'b1; o_tx = arg_r[23:16]; end
            4'd4: begin stage_nxt = 4'd5; o_txv = 1'b1; o_tx = arg_r[15:8]; end
            4'd5: begin stage_nxt = 4'd6; o_txv = 1'b1; o_tx = arg_r[7:0]; end
            4'd6: begin
              stage_nxt = 4'd7; o_txv = 1'b1;
              o_tx = (cidx_r == OPC_IDLE) ? 8'h95 : ((cidx_r == OPC_IFCOND) ? 8'h87 : 8'hFF);
            end
            4'd7: begin
              rleft_nxt = resp_lim_r;
              if (resp_lim_r == 8'd0) begin
                last_nxt = 8'hFF; ridx_nxt = 3'd0;
                if (extra_r != 3'd0) begin
                  stage_nxt = 4'd9; o_txv = 1'b1; o_tx = 8'hFF;
                end else begin
                  cmpl = 1'b1; rr = 8'hFF;
                end
              end else begin
                stage_nxt = 4'd8; o_txv = 1'b1; o_tx = 8'hFF;
              end
            end
            4'd8: begin
              rleft_nxt = rleft_r - 8'd1;
              if (i_rx != 8'hFF || rleft_r == 8'd1) begin
                last_nxt = i_rx; ridx_nxt = 3'd0;
                if (extra_r != 3'd0) begin
                  stage_nxt = 4'd9; o_txv = 1'b1; o_tx = 8'hFF;
                end else begin
                  cmpl = 1'b1; rr = i_rx;
                end
              end else begin
                o_txv = 1'b1; o_tx = 8'hFF;
              end
            end
            default: begin
              rb_we = 1'b1; ridx_nxt = ridx_r + 3'd1;
              if (ridx_nxt < extra_r && ridx_nxt < 3'd4) begin
                o_txv = 1'b1; o_tx = 8'hFF;
              end else begin
                cmpl = 1'b1;
              end
            end
          endcase
        end
        PH_TOKEN: begin
          if (i_rx == 8'hFF) begin
            wait_nxt = wait_r - 16'd1;
            if (wait_nxt != 16'd0) begin
              o_txv = 1'b1; o_tx = 8'hFF;
            end else begin
              phase_nxt = PH_IDLE; o_done = 1'b1; o_st = 2'd1;
            end
          end else if (i_rx == 8'hFE) begin
            fpos_nxt = 10'd0; phase_nxt = PH_FRAME; o_txv = 1'b1; o_tx = 8'hFF;
          end else begin
            phase_nxt = PH_IDLE; o_done = 1'b1; o_st = 2'd1;
          end
        end
        PH_FRAME: begin
          if (fpos_r >= rstart_r && rrem_r != 10'd0) begin
            o_rdv = 1'b1; o_rd = i_rx; rrem_nxt = rrem_r - 10'd1;
          end
          fpos_nxt = fpos_inc;
          if (fpos_inc < FRAME_LEN) begin
            o_txv = 1'b1; o_tx = 8'hFF;
          end else begin
            opst_nxt = (rrem_nxt != 10'd0); do_tail = 1'b1;
          end
        end
        PH_WHDR: begin
          if (fpos_r == 10'd0) begin
            fpos_nxt = 10'd1; o_txv = 1'b1; o_tx = 8'hFE;
          end else begin
            wrem_nxt = SECTOR_LEN; phase_nxt = PH_IDLE; o_done = 1'b1;
          end
        end
        PH_WDATA: begin phase_nxt = PH_IDLE; o_done = 1'b1; end
        PH_WZERO: begin
          if (wait_r != 16'd0) begin
            wait_nxt = wait_r - 16'd1; o_txv = 1'b1; o_tx = 8'h00;
          end else begin
            phase_nxt = PH_WRESP; o_txv = 1'b1; o_tx = 8'hFF;
          end
        end
        PH_WRESP: begin
          if (i_rx[4:0] == 5'h05) begin
            wait_nxt = busy_lim_r; phase_nxt = PH_WBUSY; o_txv = 1'b1; o_tx = 8'hFF;
          end else begin
            opst_nxt = 1'b1; do_tail = 1'b1;
          end
        end
        PH_WBUSY: begin
          if (i_rx == 8'hFF) begin
            opst_nxt = (wait_r == 16'd0); do_tail = 1'b1;
          end else if (wait_r == 16'd0) begin
            opst_nxt = 1'b1; do_tail = 1'b1;
          end else begin
            wait_nxt = wait_r - 16'd1; o_txv = 1'b1; o_tx = 8'hFF;
          end
        end
        PH_TAIL: begin
          phase_nxt = PH_IDLE; o_done = 1'b1;
          if (op_r == OP_INIT) o_st = (kind_r != 3'd0) ? 2'd0 : 2'd2;
          else o_st = {1'b0, opst_r};
        end
        default: ;
      endcase
    end

    // The last response byte is stored in this same transfer, so it is taken from the input.
    rb3 = (rb_we && rb_wa == 2'd3) ? i_rx : rb_r[3];

    // Command completion: an app prefix either chains or falls into the continuation.
    if (cmpl) begin
      if (apppend_r) begin
        apppend_nxt = 1'b0;
        if (rr > 8'd1) cont = 1'b1;
        else begin do_issue = 1'b1; ic = appcmd_r; ia = apparg_r; ie = appext_r; end
      end else begin
        cont = 1'b1;
      end
    end

    if (cont) begin
      case (after_r)
        K_IDLE: begin
          if (rr == 8'd1) begin
            do_start = 1'b1; sc = OPC_IFCOND; sa = 32'h1AA; se = 3'd4; sk = K_IFCOND;
          end else do_tail = 1'b1;
        end
        K_IFCOND: begin
          if (rr == 8'd1) begin
            if (rb_r[2] == 8'h01 && rb3 == 8'hAA) begin
              retry_nxt = retry_lim_r;
              if (retry_lim_r == 16'd0) do_tail = 1'b1;
              else begin
                do_start = 1'b1; sc = OPC_APPOPCOND; sa = 32'h4000_0000; sk = K_HCS;
              end
            end else do_tail = 1'b1;
          end else begin
            do_start = 1'b1; sc = OPC_APPOPCOND; sk = K_PROBE;
          end
        end
        K_HCS: begin
          if (rr != 8'd0) begin
            retry_nxt = retry_r - 16'd1;
            if (retry_nxt == 16'd0) do_tail = 1'b1;
            else begin
              do_start = 1'b1; sc = OPC_APPOPCOND; sa = 32'h4000_0000; sk = K_HCS;
            end
          end else begin
            do_start = 1'b1; sc = OPC_OCR; se = 3'd4; sk = K_OCR;
          end
        end
        K_OCR: begin
          if (rr == 8'd0) kind_nxt = rb_r[0][6] ? 3'd4 : 3'd3;
          do_tail = 1'b1;
        end
        K_PROBE: begin
          if (rr <= 8'd1) begin kind_nxt = 3'd2; poll_nxt = OPC_APPOPCOND; end
          else begin kind_nxt = 3'd1; poll_nxt = OPC_OPCOND; end
          retry_nxt = retry_lim_r;
          if (retry_lim_r == 16'd0) begin kind_nxt = 3'd0; do_tail = 1'b1; end
          else begin do_start = 1'b1; sc = poll_nxt; sk = K_LOW; end
        end
        K_LOW: begin
          if (rr != 8'd0) begin
            retry_nxt = retry_r - 16'd1;
            if (retry_nxt == 16'd0) begin kind_nxt = 3'd0; do_tail = 1'b1; end
            else begin do_start = 1'b1; sc = poll_r; sk = K_LOW; end
          end else begin
            do_start = 1'b1; sc = OPC_BLKLEN; sa = 32'd512; sk = K_BLKLEN;
          end
        end
        K_BLKLEN: begin
          if (rr != 8'd0) kind_nxt = 3'd0;
          do_tail = 1'b1;
        end
        K_RDBLK: begin
          if (rr == 8'd0) begin
            wait_nxt = token_lim_r; phase_nxt = PH_TOKEN; o_txv = 1'b1; o_tx = 8'hFF;
          end else begin
            phase_nxt = PH_IDLE; o_done = 1'b1; o_st = 2'd1;
          end
        end
        default: begin
          if (rr == 8'd0) begin
            fpos_nxt = 10'd0; phase_nxt = PH_WHDR; o_txv = 1'b1; o_tx = 8'hFF;
          end else begin
            phase_nxt = PH_IDLE; o_done = 1'b1; o_st = 2'd1;
          end
        end
      endcase
    end

    if (do_start) begin
      after_nxt = sk;
      if (sc[7]) begin
        apppend_nxt = 1'b1; appcmd_nxt = {1'b0, sc[6:0]}; apparg_nxt = sa; appext_nxt = se;
        do_issue = 1'b1; ic = OPC_APP; ia = 32'h0; ie = 3'd0;
      end else begin
        apppend_nxt = 1'b0; do_issue = 1'b1; ic = sc; ia = sa; ie = se;
      end
    end
    if (do_issue) begin
      cs_nxt = 1'b0; phase_nxt = PH_CMD; stage_nxt = 4'd0; cidx_nxt = ic; arg_nxt = ia;
      extra_nxt = ie; o_txv = 1'b1; o_tx = 8'hFF;
    end
    if (do_tail) begin
      cs_nxt = 1'b0; phase_nxt = PH_TAIL; o_txv = 1'b1; o_tx = 8'hFF;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      resp_lim_r <= 8'd128; retry_lim_r <= 16'd25000;
      token_lim_r <= 16'd40000; busy_lim_r <= 16'd5000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RESP:  resp_lim_r <= cfg_data[7:0];
        REG_RETRY: retry_lim_r <= cfg_data;
        REG_TOKEN: token_lim_r <= cfg_data;
        REG_BUSY:  busy_lim_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (take && rb_we) begin
      rb_r[rb_wa] <= i_rx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE; kind_r <= 3'd0; cidx_r <= 8'd0; arg_r <= 32'd0;
      fpos_r <= 10'd0; wait_r <= 16'd0; retry_r <= 16'd0; last_r <= 8'hFF;
      wrem_r <= 10'd0; rrem_r <= 10'd0; rstart_r <= 10'd0; cs_r <= 1'b0;
      stage_r <= 4'd0; rleft_r <= 8'd0; ridx_r <= 3'd0; extra_r <= 3'd0;
      apppend_r <= 1'b0; appcmd_r <= 8'd0; apparg_r <= 32'd0; appext_r <= 3'd0;
      after_r <= K_IDLE; poll_r <= 8'd0; op_r <= OP_INIT; opst_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_tready) out_valid_r <= 1'b0;
      if (take) begin
        phase_r <= phase_nxt; kind_r <= kind_nxt; cidx_r <= cidx_nxt; arg_r <= arg_nxt;
        fpos_r <= fpos_nxt; wait_r <= wait_nxt; retry_r <= retry_nxt; last_r <= last_nxt;
        wrem_r <= wrem_nxt; rrem_r <= rrem_nxt; rstart_r <= rstart_nxt; cs_r <= cs_nxt;
        stage_r <= stage_nxt; rleft_r <= rleft_nxt; ridx_r <= ridx_nxt;
        extra_r <= extra_nxt; apppend_r <= apppend_nxt; appcmd_r <= appcmd_nxt;
        apparg_r <= apparg_nxt; appext_r <= appext_nxt; after_r <= after_nxt;
        poll_r <= poll_nxt; op_r <= op_nxt; opst_r <= opst_nxt;
        out_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_data_r <= {7'd0, kind_nxt, o_st, o_done, o_rd, o_rdv, cs_nxt, o_tx, o_txv};
    end
  end

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    take && o_done |=> phase_r == PH_IDLE) else $error("done without return to idle");
  a_read_frame: assert property (@(posedge clk) disable iff (!rst_n)
    take && o_rdv |-> phase_r == PH_FRAME) else $error("read byte outside frame");
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready |=> $stable(out_data_r)) else $error("result lost");
  a_no_take: assert property (@(posedge clk) disable iff (!rst_n)
    !take |=> $stable(phase_r)) else $error("phase moved without transfer");
endmodule
`default_nettype wire

// ===== dv/sd_card_spi_host_engine_test.sv =====
// Self-checking testbench for sd_card_spi_host_engine: an emulated card answers
// every exchange, and a built-in predictor checks each out_ transfer field by field.
// Depends on sdspi_pkg and the engine RTL.
`timescale 1ns / 1ps
module sd_card_spi_host_engine_test;
  import sdspi_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int TOTAL_ITEMS = 1850;
  localparam int READ_ROOM = 600;

  typedef struct packed {
    logic       txv;
    logic [7:0] tx;
    logic       cs;
    logic       rdv;
    logic [7:0] rd;
    logic       done;
    logic [1:0] st;
    logic [2:0] kind;
  } step_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [71:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  sd_card_spi_host_engine u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  logic [71:0]  item_queue[$];
  step_result_t expected_results[$];
  int           mismatches = 0;
  int           item_count = 0;
  logic         hold_req = 1'b0;

  // Predictor state.
  logic [7:0]  lim_resp;
  logic [15:0] lim_retry, lim_token, lim_busy;
  logic [3:0]  ph, after_k;
  logic [2:0]  kind;
  logic [7:0]  cidx, lastr, app_c, poll_c, rleft, ridx, cextra, app_x, cstage;
  logic [31:0] carg, app_a;
  logic [9:0]  fpos, wrem, rrem, rstart;
  logic [15:0] wcnt, rcnt;
  logic [7:0]  rbytes[4];
  logic        cs, app_pend;
  logic [1:0]  cur_op, op_st;
  step_result_t res;

  // Emulated card.
  int card_profile;
  int idle_polls;

  function automatic void xfer(logic [7:0] b);
    res.txv = 1'b1;
    res.tx = b;
  endfunction

  function automatic void finish_req(logic [1:0] s);
    ph = PH_IDLE;
    res.done = 1'b1;
    res.st = s;
  endfunction

  function automatic void issue(logic [7:0] c, logic [31:0] a, logic [7:0] x);
    cs = 1'b0;
    ph = PH_CMD;
    cstage = 0;
    cidx = c;
    carg = a;
    cextra = x;
    xfer(8'hFF);
  endfunction

  function automatic void start_cmd(logic [7:0] c, logic [31:0] a, logic [7:0] x,
                                    logic [3:0] k);
    after_k = k;
    if (c[7]) begin
      app_pend = 1'b1;
      app_c = {1'b0, c[6:0]};
      app_a = a;
      app_x = x;
      issue(OPC_APP, 32'd0, 8'd0);
    end else begin
      app_pend = 1'b0;
      issue(c, a, x);
    end
  endfunction

  function automatic void tail();
    cs = 1'b0;
    ph = PH_TAIL;
    xfer(8'hFF);
  endfunction

  function automatic void poll_hcs();
    if (rcnt == 0) tail();
    else start_cmd(OPC_APPOPCOND, 32'h4000_0000, 8'd0, K_HCS);
  endfunction

  function automatic void poll_low();
    if (rcnt == 0) begin
      kind = 3'd0;
      tail();
    end else begin
      start_cmd(poll_c, 32'd0, 8'd0, K_LOW);
    end
  endfunction

  function automatic logic [31:0] blk_addr(logic [31:0] s);
    return (kind == 3'd4) ? s : {s[22:0], 9'd0};
  endfunction

  function automatic void resume(logic [7:0] r);
    case (after_k)
      K_IDLE: begin
        if (r == 8'd1) start_cmd(OPC_IFCOND, 32'h1AA, 8'd4, K_IFCOND);
        else tail();
      end
      K_IFCOND: begin
        if (r == 8'd1) begin
          if (rbytes[2] == 8'h01 && rbytes[3] == 8'hAA) begin
            rcnt = lim_retry;
            poll_hcs();
          end else begin
            tail();
          end
        end else begin
          start_cmd(OPC_APPOPCOND, 32'd0, 8'd0, K_PROBE);
        end
      end
      K_HCS: begin
        if (r != 8'd0) begin
          rcnt = rcnt - 1'b1;
          poll_hcs();
        end else begin
          start_cmd(OPC_OCR, 32'd0, 8'd4, K_OCR);
        end
      end
      K_OCR: begin
        if (r == 8'd0) kind = rbytes[0][6] ? 3'd4 : 3'd3;
        tail();
      end
      K_PROBE: begin
        if (r <= 8'd1) begin
          kind = 3'd2;
          poll_c = OPC_APPOPCOND;
        end else begin
          kind = 3'd1;
          poll_c = OPC_OPCOND;
        end
        rcnt = lim_retry;
        poll_low();
      end
      K_LOW: begin
        if (r != 8'd0) begin
          rcnt = rcnt - 1'b1;
          poll_low();
        end else begin
          start_cmd(OPC_BLKLEN, 32'd512, 8'd0, K_BLKLEN);
        end
      end
      K_BLKLEN: begin
        if (r != 8'd0) kind = 3'd0;
        tail();
      end
      K_RDBLK: begin
        if (r == 8'd0) begin
          wcnt = lim_token;
          ph = PH_TOKEN;
          xfer(8'hFF);
        end else begin
          finish_req(2'd1);
        end
      end
      default: begin
        if (r == 8'd0) begin
          fpos = 10'd0;
          ph = PH_WHDR;
          xfer(8'hFF);
        end else begin
          finish_req(2'd1);
        end
      end
    endcase
  endfunction

  function automatic void cmd_complete(logic [7:0] r);
    if (app_pend) begin
      app_pend = 1'b0;
      if (r > 8'd1) resume(r);
      else issue(app_c, app_a, app_x);
    end else begin
      resume(r);
    end
  endfunction

  function automatic void response_got();
    ridx = 8'd0;
    if (cextra > 0) begin
      cstage = 9;
      xfer(8'hFF);
    end else begin
      cmd_complete(lastr);
    end
  endfunction

  function automatic void cmd_rx(logic [7:0] rx);
    case (cstage)
      0: begin cs = 1'b1; cstage = 1; xfer(8'hFF); end
      1: begin cstage = 2; xfer(cidx); end
      2: begin cstage = 3; xfer(carg[31:24]); end
      3: begin cstage = 4; xfer(carg[23:16]); end
      4: begin cstage = 5; xfer(carg[15:8]); end
      5: begin cstage = 6; xfer(carg[7:0]); end
      6: begin
        cstage = 7;
        xfer(cidx == OPC_IDLE ? 8'h95 : (cidx == OPC_IFCOND ? 8'h87 : 8'hFF));
      end
      7: begin
        rleft = lim_resp;
        if (rleft == 0) begin
          lastr = 8'hFF;
          response_got();
        end else begin
          cstage = 8;
          xfer(8'hFF);
        end
      end
      8: begin
        rleft = rleft - 1'b1;
        if (rx != 8'hFF || rleft == 0) begin
          lastr = rx;
          response_got();
        end else begin
          xfer(8'hFF);
        end
      end
      default: begin
        rbytes[ridx[1:0]] = rx;
        ridx = ridx + 1'b1;
        if (ridx < cextra && ridx < 4) xfer(8'hFF);
        else cmd_complete(lastr);
      end
    endcase
  endfunction

  function automatic void on_rx(logic [7:0] rx);
    case (ph)
      PH_DUMMY: begin
        if (wcnt != 0) begin
          wcnt = wcnt - 1'b1;
          xfer(8'hFF);
        end else begin
          start_cmd(OPC_IDLE, 32'd0, 8'd0, K_IDLE);
        end
      end
      PH_CMD: cmd_rx(rx);
      PH_TOKEN: begin
        if (rx == 8'hFF) begin
          wcnt = wcnt - 1'b1;
          if (wcnt != 0) xfer(8'hFF);
          else finish_req(2'd1);
        end else if (rx == 8'hFE) begin
          fpos = 10'd0;
          ph = PH_FRAME;
          xfer(8'hFF);
        end else begin
          finish_req(2'd1);
        end
      end
      PH_FRAME: begin
        if (fpos >= rstart && rrem > 0) begin
          res.rdv = 1'b1;
          res.rd = rx;
          rrem = rrem - 1'b1;
        end
        fpos = fpos + 1'b1;
        if (fpos < FRAME_LEN) xfer(8'hFF);
        else begin
          op_st = (rrem != 0) ? 2'd1 : 2'd0;
          tail();
        end
      end
      PH_WHDR: begin
        if (fpos == 0) begin
          fpos = 10'd1;
          xfer(8'hFE);
        end else begin
          wrem = SECTOR_LEN;
          finish_req(2'd0);
        end
      end
      PH_WDATA: finish_req(2'd0);
      PH_WZERO: begin
        if (wcnt != 0) begin
          wcnt = wcnt - 1'b1;
          xfer(8'h00);
        end else begin
          ph = PH_WRESP;
          xfer(8'hFF);
        end
      end
      PH_WRESP: begin
        if (rx[4:0] == 5'h05) begin
          wcnt = lim_busy;
          ph = PH_WBUSY;
          xfer(8'hFF);
        end else begin
          op_st = 2'd1;
          tail();
        end
      end
      PH_WBUSY: begin
        if (rx == 8'hFF) begin
          op_st = (wcnt != 0) ? 2'd0 : 2'd1;
          tail();
        end else if (wcnt == 0) begin
          op_st = 2'd1;
          tail();
        end else begin
          wcnt = wcnt - 1'b1;
          xfer(8'hFF);
        end
      end
      PH_TAIL: finish_req(cur_op == OP_INIT ? (kind != 0 ? 2'd0 : 2'd2) : op_st);
      default: ;
    endcase
  endfunction

  function automatic void engine_step(logic [2:0] c, logic [31:0] sec, logic [9:0] off,
                                      logic [9:0] cnt, logic [7:0] wb, logic [7:0] rx);
    res = '0;
    if (ph == PH_IDLE) begin
      case (c)
        CMD_INIT: begin
          cur_op = OP_INIT;
          kind = 3'd0;
          cs = 1'b0;
          wcnt = 16'd19;
          ph = PH_DUMMY;
          xfer(8'hFF);
        end
        CMD_READ: begin
          cur_op = OP_READ;
          rstart = off;
          rrem = cnt;
          start_cmd(OPC_RDBLK, blk_addr(sec), 8'd0, K_RDBLK);
        end
        CMD_WBEGIN: begin
          cur_op = OP_WRITE;
          start_cmd(OPC_WRBLK, blk_addr(sec), 8'd0, K_WRBLK);
        end
        CMD_WDATA: begin
          cur_op = OP_WRITE;
          if (wrem != 0) begin
            wrem = wrem - 1'b1;
            ph = PH_WDATA;
            xfer(wb);
          end else begin
            finish_req(2'd0);
          end
        end
        CMD_WFIN: begin
          cur_op = OP_WRITE;
          wcnt = {6'd0, wrem} + 16'd1;
          ph = PH_WZERO;
          xfer(8'h00);
        end
        default: ;
      endcase
    end else if (c == CMD_RX) begin
      on_rx(rx);
    end
    res.cs = cs;
    res.kind = kind;
  endfunction

  function automatic void predictor_reset();
    lim_resp = 8'd128;
    lim_retry = 16'd25000;
    lim_token = 16'd40000;
    lim_busy = 16'd5000;
    ph = PH_IDLE;
    kind = 3'd0;
    cidx = 8'd0;
    carg = 32'd0;
    fpos = 10'd0;
    wcnt = 16'd0;
    rcnt = 16'd0;
    for (int i = 0; i < 4; i++) rbytes[i] = 8'd0;
    lastr = 8'hFF;
    wrem = 10'd0;
    rrem = 10'd0;
    rstart = 10'd0;
    cs = 1'b0;
    cstage = 0;
    rleft = 0;
    ridx = 0;
    cextra = 0;
    app_pend = 1'b0;
    app_c = 0;
    app_x = 0;
    app_a = 0;
    after_k = K_IDLE;
    poll_c = 0;
    cur_op = OP_INIT;
    op_st = 2'd0;
  endfunction

  // Byte the emulated card returns for the exchange the predictor just started.
  function automatic logic [7:0] card_byte();
    int p;
    p = $urandom_range(0, 99);
    if (p < 4) return 8'($urandom);
    if (ph == PH_CMD && cstage == 8) begin
      if (card_profile == 0 || p < 30) return 8'hFF;
      case (cidx)
        OPC_IDLE: return 8'h01;
        OPC_IFCOND: return (card_profile >= 3) ? 8'h01 : 8'h05;
        OPC_APP: return (card_profile == 1) ? 8'h05 : 8'h01;
        OPC_OPCOND, {1'b0, OPC_APPOPCOND[6:0]}: begin
          if (idle_polls > 0) begin
            idle_polls--;
            return 8'h01;
          end
          return 8'h00;
        end
        default: return 8'h00;
      endcase
    end
    if (ph == PH_CMD && cstage == 9) begin
      if (cidx == OPC_IFCOND) return (ridx == 2) ? 8'h01 : (ridx == 3) ? 8'hAA : 8'h00;
      if (cidx == OPC_OCR && ridx == 0) return (card_profile == 4) ? 8'hC0 : 8'h80;
      return 8'($urandom);
    end
    case (ph)
      PH_TOKEN: return (p < 30) ? 8'hFF : 8'hFE;
      PH_WRESP: return (p < 94) ? {3'($urandom), 5'h05} : 8'($urandom);
      PH_WBUSY: return (p < 40) ? 8'h00 : 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic push_item(logic [2:0] c, logic [31:0] sec, logic [9:0] off, logic [9:0] cnt,
                           logic [7:0] wb, logic [7:0] rx);
    engine_step(c, sec, off, cnt, wb, rx);
    item_queue.push_back({1'b0, rx, wb, cnt, off, sec, c});
    expected_results.push_back(res);
    item_count++;
  endtask

  // One host request followed by the card side of every exchange it starts, with random noise items mixed in.
  task automatic run_request(logic [2:0] c, logic [31:0] sec, logic [9:0] off,
                             logic [9:0] cnt, logic [7:0] wb, int noise_pct);
    logic busy;
    if (c == CMD_INIT) begin
      card_profile = $urandom_range(0, 12);
      if (card_profile > 4) card_profile = $urandom_range(1, 4);
      idle_polls = $urandom_range(0, 4);
    end
    push_item(c, sec, off, cnt, wb, 8'($urandom));
    busy = res.txv;
    while (busy) begin
      if ($urandom_range(0, 99) < noise_pct)
        push_item(3'($urandom_range(0, 7)), $urandom, 10'($urandom_range(0, 513)),
                  10'($urandom_range(0, 512)), 8'($urandom), 8'($urandom));
      if (ph == PH_IDLE) break;
      push_item(CMD_RX, $urandom, 10'($urandom), 10'($urandom), 8'($urandom), card_byte());
      busy = res.txv;
    end
  endtask

  task automatic write_sector(int n);
    run_request(CMD_WBEGIN, $urandom, 10'd0, 10'd0, 8'd0, 1);
    for (int i = 0; i < n; i++)
      run_request(CMD_WDATA, $urandom, 10'd0, 10'd0, 8'($urandom), 1);
    run_request(CMD_WFIN, $urandom, 10'd0, 10'd0, 8'd0, 1);
  endtask

  task automatic drain();
    while (item_queue.size() != 0 || expected_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_RESP: lim_resp = val[7:0];
      REG_RETRY: lim_retry = val;
      REG_TOKEN: lim_token = val;
      default: lim_busy = val;
    endcase
  endtask

  // Spends an even share of the items left for the run; reads only while a full frame fits.
  task automatic random_traffic(int phases_left);
    int target;
    int p;
    target = item_count + (TOTAL_ITEMS - item_count) / phases_left;
    while (item_count < target) begin
      p = $urandom_range(0, 99);
      if (p < 12) begin
        run_request(CMD_INIT, $urandom, 10'($urandom), 10'($urandom), 8'($urandom), 1);
      end else if (p < 50 && TOTAL_ITEMS - item_count >= READ_ROOM) begin
        if ($urandom_range(0, 9) == 0)
          run_request(CMD_READ, $urandom, 10'($urandom_range(0, 513)),
                      10'($urandom_range(0, 512)), 8'($urandom), 1);
        else
          run_request(CMD_READ, $urandom, 10'($urandom_range(0, 20)),
                      10'($urandom_range(0, 12)), 8'($urandom), 1);
      end else if (p < 80) begin
        write_sector($urandom_range(0, 8));
      end else if (p < 90) begin
        run_request(3'($urandom_range(CMD_WDATA, CMD_WFIN)), $urandom, 10'd0, 10'd0,
                    8'($urandom), 1);
      end else begin
        push_item(3'($urandom_range(5, 7)), $urandom, 10'($urandom), 10'($urandom),
                  8'($urandom), 8'($urandom));
      end
    end
  endtask

  initial begin
    predictor_reset();
    card_profile = 4;
    idle_polls = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part.
    push_item(CMD_RX, 32'hFFFF_FFFF, 10'h3FF, 10'h3FF, 8'hFF, 8'hFF);
    push_item(3'd6, 32'd0, 10'd0, 10'd0, 8'd0, 8'd0);
    push_item(3'd7, 32'd0, 10'd0, 10'd0, 8'd0, 8'd0);
    run_request(CMD_WDATA, 32'd0, 10'd0, 10'd0, 8'hA5, 0);
    run_request(CMD_WFIN, 32'd0, 10'd0, 10'd0, 8'd0, 0);
    run_request(CMD_INIT, 32'd0, 10'd0, 10'd0, 8'd0, 0);
    hold_req = 1'b1;
    run_request(CMD_READ, 32'hFFFF_FFFF, 10'd2, 10'd512, 8'd0, 0);
    write_sector(3);
    run_request(CMD_WDATA, 32'd0, 10'd0, 10'd0, 8'h5A, 0);
    drain();

    random_traffic(4);
    drain();
    write_reg(REG_RESP, 16'd1);
    write_reg(REG_RETRY, 16'd1);
    write_reg(REG_TOKEN, 16'd1);
    write_reg(REG_BUSY, 16'd1);
    random_traffic(3);
    drain();
    write_reg(REG_RESP, 16'd255);
    write_reg(REG_RETRY, 16'd65535);
    write_reg(REG_TOKEN, 16'd65535);
    write_reg(REG_BUSY, 16'd65535);
    random_traffic(2);
    drain();
    write_reg(REG_RESP, 16'($urandom_range(2, 16)));
    write_reg(REG_RETRY, 16'($urandom_range(2, 6)));
    write_reg(REG_TOKEN, 16'($urandom_range(2, 6)));
    write_reg(REG_BUSY, 16'($urandom_range(2, 6)));
    random_traffic(1);
    drain();

    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  int  send_gap = 0;
  bit  send_burst = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!(in_tvalid && !in_tready)) begin
      if (in_tvalid) void'(item_queue.pop_front());
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_tvalid <= 1'b0;
      end else if (item_queue.size() != 0) begin
        in_tvalid <= 1'b1;
        in_tdata <= item_queue[0];
        if ($urandom_range(0, 199) == 0) send_burst <= ~send_burst;
        send_gap <= send_burst ? 0 : $urandom_range(0, 18);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  int  recv_gap = 0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;
  bit  recv_burst = 1'b0;
  step_result_t got;
  step_result_t want;

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got = '0;
      got.txv = out_tdata[0];
      got.tx = out_tdata[8:1];
      got.cs = out_tdata[9];
      got.rdv = out_tdata[10];
      got.rd = out_tdata[18:11];
      got.done = out_tdata[19];
      got.st = out_tdata[21:20];
      got.kind = out_tdata[24:22];
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected out transfer %h", out_tdata);
      end else begin
        want = expected_results.pop_front();
        if (got != want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch at %0t: expected %p, actual %p", $realtime, want, got);
        end
      end
      if ($urandom_range(0, 199) == 0) recv_burst <= ~recv_burst;
      recv_gap <= recv_burst ? 0 : $urandom_range(0, 18);
    end
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= 400;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (out_tvalid && out_tready) begin
      out_tready <= recv_burst;
    end else if (recv_gap > 0) begin
      recv_gap <= recv_gap - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  int idle_cycles = 0;

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end
endmodule

// ===== sd_card_spi_host_engine.f =====
src/sdspi_pkg.sv
src/sd_card_spi_host_engine.sv
dv/sd_card_spi_host_engine_test.sv
